// ----- sv/blt_pkg.sv -----
// shared types, codes and constants of the backlight timeout and fade controller
`timescale 1ns / 1ps

package blt_pkg;

    // fixed field widths
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned ALS_W   = 16;
    localparam int unsigned REQ_W   = 4;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned PROD_W  = 14;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // brightness levels
    localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;
    localparam logic [PCT_W-1:0] LOW_POWER_PCT = 7'd25;
    localparam logic [PCT_W-1:0] DIM_PCT       = 7'd10;

    // fade timing
    localparam int unsigned FADE_STEPS   = 20;
    localparam int unsigned FADE_TIME_MS = 500;
    localparam logic [ALS_W-1:0] FADE_TICK_MS = 16'(FADE_TIME_MS / FADE_STEPS);

    // divide by 100 as multiply by reciprocal, exact for products up to 10000
    localparam int unsigned DIV100_SH = 19;
    localparam logic [12:0] DIV100_MUL = 13'd5243;

    // brightness / FADE_STEPS for every 7-bit brightness
    typedef logic [127:0][PCT_W-1:0] t_fade_tab;

    function automatic t_fade_tab build_fade_tab();
        t_fade_tab tab;
        for (int i = 0; i < 128; i++) begin
            tab[i] = PCT_W'(i / FADE_STEPS);
        end
        return tab;
    endfunction

    localparam t_fade_tab FADE_TAB = build_fade_tab();

    // event codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK        = 4'd0,
        REQ_PRESS       = 4'd1,
        REQ_RELEASE     = 4'd2,
        REQ_INTERACT    = 4'd3,
        REQ_FORCE       = 4'd4,
        REQ_RESPECT     = 4'd5,
        REQ_RESET_USER  = 4'd6,
        REQ_TO_TIMED    = 4'd7,
        REQ_ALLOW       = 4'd8
    } t_req;

    // intensity modes
    localparam logic [1:0] IMODE_USER    = 2'd0;
    localparam logic [1:0] IMODE_DYNAMIC = 2'd1;
    localparam logic [1:0] IMODE_LOWPWR  = 2'd2;

    // light state machine
    typedef enum logic [3:0] {
        ST_ON     = 4'b0001,
        ST_TIMED  = 4'b0010,
        ST_FADING = 4'b0100,
        ST_OFF    = 4'b1000
    } t_state;

    // reported state codes
    localparam logic [CODE_W-1:0] CODE_ON     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_TIMED  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_FADING = 2'd2;
    localparam logic [CODE_W-1:0] CODE_OFF    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_PREF      = 3'd0;
    localparam logic [2:0] REG_GATE      = 3'd1;
    localparam logic [2:0] REG_DARK      = 3'd2;
    localparam logic [2:0] REG_DIM       = 3'd3;
    localparam logic [2:0] REG_IMODE     = 3'd4;
    localparam logic [2:0] REG_USER_INT  = 3'd5;
    localparam logic [2:0] REG_TIMEOUT   = 3'd6;
    localparam logic [2:0] REG_HW_SCALE  = 3'd7;

    // configuration seen by the state machine
    typedef struct packed {
        logic             light_pref_enabled;
        logic             ambient_gate_enable;
        logic [ALS_W-1:0] dark_threshold;
        logic [ALS_W-1:0] dim_threshold;
        logic [1:0]       intensity_mode;
        logic [PCT_W-1:0] user_intensity;
        logic [ALS_W-1:0] timeout_ms;
        logic [PCT_W-1:0] hw_scale_percent;
    } t_cfg;

    // result of one item before drive scaling
    typedef struct packed {
        logic [PCT_W-1:0]  brightness_pct;
        logic [PROD_W-1:0] product;
        logic              lamp_lit;
        logic [CODE_W-1:0] light_state;
        logic              count_error;
    } t_res;

endpackage

// ----- sv/blt_cfg.sv -----
// configuration register bank behind the apb-style port
`timescale 1ns / 1ps

module blt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blt_pkg::ADDR_W-1:0]    paddr,
    input  logic [blt_pkg::DATA_W-1:0]    pwdata,
    output logic [blt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output blt_pkg::t_cfg                 o_cfg
);

    blt_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_pref_enabled  <= 1'b1;
            r_cfg.ambient_gate_enable <= 1'b0;
            r_cfg.dark_threshold      <= '0;
            r_cfg.dim_threshold       <= '0;
            r_cfg.intensity_mode      <= blt_pkg::IMODE_USER;
            r_cfg.user_intensity      <= blt_pkg::PCT_MAX;
            r_cfg.timeout_ms          <= 16'd3000;
            r_cfg.hw_scale_percent    <= blt_pkg::PCT_MAX;
        end else if (w_wr) begin
            unique case (w_idx)
                blt_pkg::REG_PREF:     r_cfg.light_pref_enabled  <= pwdata[0];
                blt_pkg::REG_GATE:     r_cfg.ambient_gate_enable <= pwdata[0];
                blt_pkg::REG_DARK:     r_cfg.dark_threshold      <= pwdata[15:0];
                blt_pkg::REG_DIM:      r_cfg.dim_threshold       <= pwdata[15:0];
                blt_pkg::REG_IMODE:    r_cfg.intensity_mode      <= pwdata[1:0];
                blt_pkg::REG_USER_INT: r_cfg.user_intensity      <= pwdata[6:0];
                blt_pkg::REG_TIMEOUT:  r_cfg.timeout_ms          <= pwdata[15:0];
                blt_pkg::REG_HW_SCALE: r_cfg.hw_scale_percent    <= pwdata[6:0];
                default:               r_cfg.light_pref_enabled  <= r_cfg.light_pref_enabled;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            blt_pkg::REG_PREF:     prdata = 32'(r_cfg.light_pref_enabled);
            blt_pkg::REG_GATE:     prdata = 32'(r_cfg.ambient_gate_enable);
            blt_pkg::REG_DARK:     prdata = 32'(r_cfg.dark_threshold);
            blt_pkg::REG_DIM:      prdata = 32'(r_cfg.dim_threshold);
            blt_pkg::REG_IMODE:    prdata = 32'(r_cfg.intensity_mode);
            blt_pkg::REG_USER_INT: prdata = 32'(r_cfg.user_intensity);
            blt_pkg::REG_TIMEOUT:  prdata = 32'(r_cfg.timeout_ms);
            blt_pkg::REG_HW_SCALE: prdata = 32'(r_cfg.hw_scale_percent);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/blt_fsm.sv -----
// light state machine: state registers and next-state logic for one item
`timescale 1ns / 1ps

module blt_fsm #(
    parameter int unsigned MAX_BUTTONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [blt_pkg::REQ_W-1:0]     i_req_type,
    input  logic                          i_flag,
    input  logic [blt_pkg::ALS_W-1:0]     i_als_level,
    input  blt_pkg::t_cfg                 i_cfg,
    output blt_pkg::t_res                 o_res
);

    localparam int unsigned BD_W = $clog2(MAX_BUTTONS + 1);

    localparam logic [BD_W:0] BD_MAX = (BD_W + 1)'(MAX_BUTTONS);

    blt_pkg::t_state                r_state, n_state;
    logic [blt_pkg::PCT_W-1:0]      r_bright, n_bright;
    logic [BD_W-1:0]                r_bd, n_bd;
    logic                           r_override, n_override;
    logic                           r_allow, n_allow;
    logic [blt_pkg::PCT_W-1:0]      r_step, n_step;
    logic [blt_pkg::ALS_W-1:0]      r_cd, n_cd;
    logic                           r_run, n_run;

    logic [blt_pkg::PCT_W-1:0]      w_ui;
    logic [blt_pkg::PCT_W-1:0]      w_scale;
    logic [blt_pkg::PCT_W-1:0]      w_on_int;
    logic                           w_allowed;
    logic [BD_W:0]                  w_bd_inc;
    logic [BD_W-1:0]                w_bd_rel;
    logic [blt_pkg::ALS_W-1:0]      w_cd_dec;
    logic [blt_pkg::PCT_W-1:0]      w_fade_q;
    logic [blt_pkg::PCT_W-1:0]      w_fstep;
    logic                           w_go;
    blt_pkg::t_state                w_tgt;
    logic                           w_err;
    logic [blt_pkg::CODE_W-1:0]     w_code;
    logic [blt_pkg::ALS_W-1:0]      w_cd_ev;
    logic                           w_run_ev;

    // saturated settings and on brightness
    always_comb begin
        w_ui    = (i_cfg.user_intensity > blt_pkg::PCT_MAX) ?
                  blt_pkg::PCT_MAX : i_cfg.user_intensity;
        w_scale = (i_cfg.hw_scale_percent > blt_pkg::PCT_MAX) ?
                  blt_pkg::PCT_MAX : i_cfg.hw_scale_percent;
        if (i_cfg.intensity_mode == blt_pkg::IMODE_LOWPWR) begin
            w_on_int = blt_pkg::LOW_POWER_PCT;
        end else if (i_cfg.intensity_mode == blt_pkg::IMODE_DYNAMIC &&
                     i_als_level <= i_cfg.dim_threshold) begin
            w_on_int = blt_pkg::DIM_PCT;
        end else begin
            w_on_int = w_ui;
        end
    end

    // permission to turn on, ambient gate only from dark
    assign w_allowed = r_allow && i_cfg.light_pref_enabled &&
                       !(i_cfg.ambient_gate_enable && r_bright == '0 &&
                         i_als_level > i_cfg.dark_threshold);

    assign w_bd_inc = {1'b0, r_bd} + (BD_W + 1)'(1);
    assign w_bd_rel = (r_bd == '0) ? r_bd : r_bd - BD_W'(1);
    assign w_cd_dec = (r_cd != '0) ? r_cd - 16'd1 : r_cd;
    assign w_fade_q = blt_pkg::FADE_TAB[r_bright];

    // event decode
    always_comb begin
        n_bd       = r_bd;
        n_override = r_override;
        n_allow    = r_allow;
        w_cd_ev    = r_cd;
        w_run_ev   = r_run;
        w_go       = 1'b0;
        w_tgt      = blt_pkg::ST_OFF;
        w_err      = 1'b0;
        unique case (i_req_type)
            blt_pkg::REQ_TICK: begin
                if (r_run) begin
                    w_cd_ev = w_cd_dec;
                    if (w_cd_dec == '0) begin
                        w_run_ev = 1'b0;
                        w_go     = 1'b1;
                        w_tgt    = blt_pkg::ST_FADING;
                    end
                end
            end
            blt_pkg::REQ_PRESS: begin
                if (w_bd_inc > BD_MAX) begin
                    n_bd  = '0;
                    w_err = 1'b1;
                end else begin
                    n_bd = w_bd_inc[BD_W-1:0];
                end
                if (w_allowed) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_ON;
                end
            end
            blt_pkg::REQ_RELEASE: begin
                w_err = (r_bd == '0);
                n_bd  = w_bd_rel;
                if (w_bd_rel == '0 && r_state == blt_pkg::ST_ON && !r_override) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_TIMED;
                end
            end
            blt_pkg::REQ_INTERACT: begin
                if (r_bd == '0 && r_state != blt_pkg::ST_ON && w_allowed) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_TIMED;
                end
            end
            blt_pkg::REQ_FORCE: begin
                n_override = i_flag;
                if (i_flag) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_ON;
                end else if (r_bd == '0) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_OFF;
                end
            end
            blt_pkg::REQ_RESPECT: begin
                n_override = i_flag;
                if (i_flag) begin
                    if (w_allowed) begin
                        w_go  = 1'b1;
                        w_tgt = blt_pkg::ST_ON;
                    end
                end else if (r_bd == '0) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_OFF;
                end
            end
            blt_pkg::REQ_RESET_USER: begin
                if (r_override) begin
                    n_override = 1'b0;
                    if (r_bd == '0) begin
                        w_go  = 1'b1;
                        w_tgt = blt_pkg::ST_OFF;
                    end
                end
            end
            blt_pkg::REQ_TO_TIMED: begin
                if (r_override) begin
                    n_override = 1'b0;
                    if (w_allowed) begin
                        w_go  = 1'b1;
                        w_tgt = blt_pkg::ST_TIMED;
                    end
                end
            end
            blt_pkg::REQ_ALLOW: begin
                if (r_allow && !i_flag) begin
                    w_go  = 1'b1;
                    w_tgt = blt_pkg::ST_OFF;
                end
                n_allow = i_flag;
            end
            default: begin
                n_allow = r_allow;
            end
        endcase
    end

    // fade step, fresh on entry into fading
    always_comb begin
        if (r_state != blt_pkg::ST_FADING) begin
            w_fstep = (w_fade_q == '0) ? 7'd1 : w_fade_q;
        end else begin
            w_fstep = r_step;
        end
    end

    // state transition
    always_comb begin
        n_state  = r_state;
        n_bright = r_bright;
        n_step   = r_step;
        n_cd     = w_cd_ev;
        n_run    = w_run_ev;
        if (w_go) begin
            unique case (w_tgt)
                blt_pkg::ST_ON: begin
                    n_state  = blt_pkg::ST_ON;
                    n_bright = w_on_int;
                    n_run    = 1'b0;
                    n_cd     = '0;
                end
                blt_pkg::ST_TIMED: begin
                    n_state  = blt_pkg::ST_TIMED;
                    n_bright = w_on_int;
                    n_cd     = i_cfg.timeout_ms;
                    n_run    = 1'b1;
                end
                blt_pkg::ST_FADING: begin
                    n_step = w_fstep;
                    if (w_fstep >= r_bright) begin
                        n_state  = blt_pkg::ST_OFF;
                        n_bright = '0;
                        n_run    = 1'b0;
                        n_cd     = '0;
                    end else begin
                        n_state  = blt_pkg::ST_FADING;
                        n_bright = r_bright - w_fstep;
                        n_cd     = blt_pkg::FADE_TICK_MS;
                        n_run    = 1'b1;
                    end
                end
                default: begin
                    n_state  = blt_pkg::ST_OFF;
                    n_bright = '0;
                    n_run    = 1'b0;
                    n_cd     = '0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= blt_pkg::ST_OFF;
            r_bright   <= '0;
            r_bd       <= '0;
            r_override <= 1'b0;
            r_allow    <= 1'b0;
            r_step     <= '0;
            r_cd       <= '0;
            r_run      <= 1'b0;
        end else if (i_fire) begin
            r_state    <= n_state;
            r_bright   <= n_bright;
            r_bd       <= n_bd;
            r_override <= n_override;
            r_allow    <= n_allow;
            r_step     <= n_step;
            r_cd       <= n_cd;
            r_run      <= n_run;
        end
    end

    // state code for the result
    always_comb begin
        unique case (n_state)
            blt_pkg::ST_ON:     w_code = blt_pkg::CODE_ON;
            blt_pkg::ST_TIMED:  w_code = blt_pkg::CODE_TIMED;
            blt_pkg::ST_FADING: w_code = blt_pkg::CODE_FADING;
            default:            w_code = blt_pkg::CODE_OFF;
        endcase
    end

    // result of this item, drive product before the divide
    assign o_res.brightness_pct = n_bright;
    assign o_res.product        = blt_pkg::PROD_W'(n_bright) * blt_pkg::PROD_W'(w_scale);
    assign o_res.lamp_lit       = (n_state != blt_pkg::ST_OFF);
    assign o_res.light_state    = w_code;
    assign o_res.count_error    = w_err;

endmodule

// ----- sv/backlight_timeout_fade_controller.sv -----
// top level: item input register, state machine, result register and config port
`timescale 1ns / 1ps

// Backlight controller fed by events on a stream slave channel.
// Slave: tuser carries the event kind, tdata carries the flag and the
// ambient light sample. Master: one result item per event with the
// brightness percent, the drive level, the on bit, the state code and
// the button count error bit.
// Every event passes an input register and then the state machine,
// whose result lands in an output register, from which it is shown.
// One event is taken every cycle as long as the result side keeps up;
// the output register and the input register let the slave side
// accept while a result waits. When the receiver stalls, the results
// hold and tready drops once both registers are full. Reset
// (synchronous, active low) puts the light in the off state with all
// counters cleared and loads the register defaults. Registers are to be
// written by the user over the apb-style port only while no event is
// in flight; the block itself does not enforce this.
module backlight_timeout_fade_controller #(
    parameter int unsigned MAX_BUTTONS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave item channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // flag [0], als_level [16:1], zero fill
    input  logic [3:0]  i_s_axis_tuser,   // req_type [3:0]
    // master item channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // brightness_pct [6:0], drive_level [13:7],
                                          // lamp_lit [14], light_state [16:15],
                                          // count_error [17], zero fill
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    blt_pkg::t_cfg                  w_cfg;
    blt_pkg::t_res                  w_res;

    logic                           r_in_valid;
    logic [blt_pkg::REQ_W-1:0]      r_req;
    logic                           r_flag;
    logic [blt_pkg::ALS_W-1:0]      r_als;
    logic                           r_out_valid;
    blt_pkg::t_res                  r_res;

    logic                           w_out_free;
    logic                           w_fire;
    logic                           w_in_take;
    logic [26:0]                    w_drive_full;

    // pipeline handshake
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req  <= i_s_axis_tuser;
            r_flag <= i_s_axis_tdata[0];
            r_als  <= i_s_axis_tdata[16:1];
        end
    end

    blt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    blt_fsm #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_req_type  (r_req),
        .i_flag      (r_flag),
        .i_als_level (r_als),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    // divide the registered product by 100
    assign w_drive_full = 27'(r_res.product) * 27'(blt_pkg::DIV100_MUL);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0,
                              r_res.count_error,
                              r_res.light_state,
                              r_res.lamp_lit,
                              w_drive_full[blt_pkg::DIV100_SH +: blt_pkg::PCT_W],
                              r_res.brightness_pct};

endmodule
